[rtl/core/vwadpcm_pkg.sv]
`default_nettype none
package vwadpcm_pkg;

    localparam int MAX_CHANNELS_DEF = 2;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 7;
    localparam int CODE_W   = 5;
    localparam int START_INDEX_W = 6;
    localparam int NBITS_W  = 3;
    localparam int CHCNT_W  = 2;
    localparam int MULT_W   = 4;
    localparam int COPIES_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [INDEX_W-1:0] INDEX_MAX = 7'd88;
    localparam logic signed [SAMPLE_W+1:0] SAMPLE_POS_MAX = 18'sd32767;
    localparam logic signed [SAMPLE_W+1:0] SAMPLE_NEG_MAX = -18'sd32768;

    localparam logic [NBITS_W-1:0] CODE_BITS_RST  = 3'd4;
    localparam logic [CHCNT_W-1:0] CHAN_COUNT_RST = 2'd1;
    localparam logic [MULT_W-1:0]  RATE_MULT_RST  = 4'd1;
    localparam logic [CHCNT_W-1:0] CHAN_STEREO    = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODE_BITS  = 2'd0,
        CFG_CHAN_COUNT = 2'd1,
        CFG_RATE_MULT  = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        CMD_HEADER = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] predictor;
        logic [INDEX_W-1:0]         step_index;
    } chan_state_t;

    localparam logic [14:0] STEP_SIZES [0:88] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
        15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
        15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
        15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
        15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
        15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
        15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
        15'd27086, 15'd29794, 15'd32767
    };

    function automatic logic signed [5:0] index_adjust(
        input logic [NBITS_W-1:0] nbits,
        input logic [3:0]         mag
    );
        logic signed [5:0] adj;
        adj = -6'sd1;
        case (nbits)
            3'd2:
            begin
                adj = mag[0] ? 6'sd2 : -6'sd1;
            end
            3'd3:
            begin
                case (mag[1:0])
                    2'd2:    adj = 6'sd2;
                    2'd3:    adj = 6'sd4;
                    default: adj = -6'sd1;
                endcase
            end
            3'd4:
            begin
                case (mag[2:0])
                    3'd4:    adj = 6'sd2;
                    3'd5:    adj = 6'sd4;
                    3'd6:    adj = 6'sd6;
                    3'd7:    adj = 6'sd8;
                    default: adj = -6'sd1;
                endcase
            end
            default:
            begin
                case (mag)
                    4'd8:    adj = 6'sd1;
                    4'd9:    adj = 6'sd2;
                    4'd10:   adj = 6'sd4;
                    4'd11:   adj = 6'sd6;
                    4'd12:   adj = 6'sd8;
                    4'd13:   adj = 6'sd10;
                    4'd14:   adj = 6'sd13;
                    4'd15:   adj = 6'sd16;
                    default: adj = -6'sd1;
                endcase
            end
        endcase
        return adj;
    endfunction

endpackage
`default_nettype wire

[rtl/core/variable_width_adpcm_decoder.sv]
`default_nettype none
// ADPCM decoder for 2 to 5 bit codes on up to MAX_CHANNELS channels. Requests enter at up to
// one per cycle: the channel state (predictor, step index) is read from a small synchronous
// memory, then updated and written back as the request leaves the stage register, with
// write-first forwarding so that requests for the same channel may follow back to back. Each
// request yields as many copies of its sample as the repeat register asks (twice that in
// mono), 1 to 16 results, one per cycle while out_ready is high, so the output repeater
// sets the sustained rate. out_valid rises once a request has passed the stage and repeater
// registers. Configuration must be written only while idle; the block does not enforce it.
module variable_width_adpcm_decoder
    import vwadpcm_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       cmd,
    input  wire logic                       channel,
    input  wire logic [CODE_W-1:0]          code,
    input  wire logic signed [SAMPLE_W-1:0] start_sample,
    input  wire logic [START_INDEX_W-1:0]   start_index,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [SAMPLE_W-1:0]      sample,
    output logic                            sample_channel,
    output logic                            last,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [NBITS_W-1:0] code_bits_reg;
    logic [CHCNT_W-1:0] channel_count_reg;
    logic [MULT_W-1:0]  rep_mult_reg;

    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_cmd_reg;
    logic [CH_W-1:0]            s1_ch_reg;
    logic [CODE_W-1:0]          s1_code_reg;
    logic signed [SAMPLE_W-1:0] s1_start_sample_reg;
    logic [START_INDEX_W-1:0]   s1_start_index_reg;

    logic               accept;
    logic               s1_fire;
    logic               slot_free;
    logic [CH_W-1:0]    ch_eff;
    logic [NBITS_W-1:0] nbits;
    logic [MULT_W-1:0]  mult;
    logic [COPIES_W-1:0] copies;
    chan_state_t        cur_state;
    chan_state_t        nxt_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_bits_reg     <= CODE_BITS_RST;
            channel_count_reg <= CHAN_COUNT_RST;
            rep_mult_reg      <= RATE_MULT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CODE_BITS:  code_bits_reg     <= cfg_data[NBITS_W-1:0];
                CFG_CHAN_COUNT: channel_count_reg <= cfg_data[CHCNT_W-1:0];
                CFG_RATE_MULT:  rep_mult_reg      <= cfg_data[MULT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (code_bits_reg < 3'd2)
        begin
            nbits = 3'd2;
        end
        else if (code_bits_reg > 3'd5)
        begin
            nbits = 3'd5;
        end
        else
        begin
            nbits = code_bits_reg;
        end
        if (rep_mult_reg == '0)
        begin
            mult = 4'd1;
        end
        else if (rep_mult_reg > 4'd8)
        begin
            mult = 4'd8;
        end
        else
        begin
            mult = rep_mult_reg;
        end
        copies = (channel_count_reg == CHAN_STEREO) ? {1'b0, mult} : {mult, 1'b0};
    end

    assign ch_eff   = (32'(channel) < MAX_CHANNELS) ? CH_W'(channel) : '0;
    assign s1_fire  = s1_valid_reg && slot_free;
    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg          <= cmd;
            s1_ch_reg           <= ch_eff;
            s1_code_reg         <= code;
            s1_start_sample_reg <= start_sample;
            s1_start_index_reg  <= start_index;
        end
    end

    vwadpcm_state_mem #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CH_W         (CH_W)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (ch_eff),
        .rd_data (cur_state),
        .wr_en   (s1_fire),
        .wr_addr (s1_ch_reg),
        .wr_data (nxt_state)
    );

    vwadpcm_decode u_decode (
        .cmd          (s1_cmd_reg),
        .code         (s1_code_reg),
        .start_sample (s1_start_sample_reg),
        .start_index  (s1_start_index_reg),
        .nbits        (nbits),
        .cur_state    (cur_state),
        .nxt_state    (nxt_state)
    );

    vwadpcm_repeat u_repeat (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (s1_fire),
        .load_sample    (nxt_state.predictor),
        .load_channel   (1'(s1_ch_reg)),
        .load_copies    (copies),
        .free           (slot_free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample         (sample),
        .sample_channel (sample_channel),
        .last           (last)
    );

`ifndef SYNTHESIS
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted request lost");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> s1_valid_reg && $stable(s1_ch_reg)
            && $stable(s1_code_reg))
        else $error("stalled request changed");
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |-> (nxt_state.step_index <= INDEX_MAX))
        else $error("step index out of range");
`endif

endmodule
`default_nettype wire

[rtl/core/vwadpcm_state_mem.sv]
`default_nettype none
module vwadpcm_state_mem
    import vwadpcm_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int CH_W = 1
)(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            rd_en,
    input  wire logic [CH_W-1:0] rd_addr,
    output chan_state_t          rd_data,
    input  wire logic            wr_en,
    input  wire logic [CH_W-1:0] wr_addr,
    input  wire chan_state_t     wr_data
);

    chan_state_t mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] vld_reg;
    chan_state_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // write-first: a read that meets a write to the same entry sees the new state
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (vld_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[rtl/core/vwadpcm_decode.sv]
`default_nettype none
module vwadpcm_decode
    import vwadpcm_pkg::*;
(
    input  wire logic                       cmd,
    input  wire logic [CODE_W-1:0]          code,
    input  wire logic signed [SAMPLE_W-1:0] start_sample,
    input  wire logic [START_INDEX_W-1:0]   start_index,
    input  wire logic [NBITS_W-1:0]         nbits,
    input  wire chan_state_t                cur_state,
    output chan_state_t                     nxt_state
);

    logic [CODE_W-1:0]         code_m;
    logic                      sign;
    logic [3:0]                mag;
    logic [INDEX_W-1:0]        cur_idx;
    logic [16:0]               step;
    logic [16:0]               diff;
    logic signed [SAMPLE_W+1:0] pred_sum;
    logic signed [7:0]         idx_sum;
    logic [INDEX_W-1:0]        hdr_idx;

    always_comb
    begin
        code_m  = code & CODE_W'((6'd1 << nbits) - 6'd1);
        sign    = code_m[nbits - 3'd1];
        mag     = 4'(code_m & CODE_W'((6'd1 << (nbits - 3'd1)) - 6'd1));
        cur_idx = (cur_state.step_index > INDEX_MAX) ? INDEX_MAX : cur_state.step_index;
        step    = {2'b00, STEP_SIZES[cur_idx]};
        diff    = step >> (nbits - 3'd1);
        for (int k = 0; k < 4; k++)
        begin
            if ((3'(k) < (nbits - 3'd1)) && mag[k])
            begin
                diff = diff + (step >> (nbits - 3'd2 - 3'(k)));
            end
        end
        pred_sum = sign ?
            ({{2{cur_state.predictor[SAMPLE_W-1]}}, cur_state.predictor} - $signed({1'b0, diff}))
          : ({{2{cur_state.predictor[SAMPLE_W-1]}}, cur_state.predictor} + $signed({1'b0, diff}));
        idx_sum  = $signed({1'b0, cur_idx}) + 8'(index_adjust(nbits, mag));
        hdr_idx  = ({1'b0, start_index} > INDEX_MAX) ? INDEX_MAX : {1'b0, start_index};

        if (cmd == CMD_HEADER)
        begin
            nxt_state.predictor  = start_sample;
            nxt_state.step_index = hdr_idx;
        end
        else
        begin
            if (pred_sum > SAMPLE_POS_MAX)
            begin
                nxt_state.predictor = SAMPLE_POS_MAX[SAMPLE_W-1:0];
            end
            else if (pred_sum < SAMPLE_NEG_MAX)
            begin
                nxt_state.predictor = SAMPLE_NEG_MAX[SAMPLE_W-1:0];
            end
            else
            begin
                nxt_state.predictor = pred_sum[SAMPLE_W-1:0];
            end
            if (idx_sum < 8'sd0)
            begin
                nxt_state.step_index = '0;
            end
            else if (idx_sum > $signed({1'b0, INDEX_MAX}))
            begin
                nxt_state.step_index = INDEX_MAX;
            end
            else
            begin
                nxt_state.step_index = idx_sum[INDEX_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/vwadpcm_repeat.sv]
`default_nettype none
module vwadpcm_repeat
    import vwadpcm_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       load,
    input  wire logic signed [SAMPLE_W-1:0] load_sample,
    input  wire logic                       load_channel,
    input  wire logic [COPIES_W-1:0]        load_copies,
    output logic                            free,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [SAMPLE_W-1:0]      sample,
    output logic                            sample_channel,
    output logic                            last
);

    logic                        valid_reg, valid_next;
    logic [COPIES_W-1:0]         cnt_reg, cnt_next;
    logic signed [SAMPLE_W-1:0]  sample_reg;
    logic                        chan_reg;
    logic                        done;

    assign done = valid_reg && out_ready && (cnt_reg == COPIES_W'(1));
    assign free = !valid_reg || done;

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            valid_next = 1'b1;
            cnt_next   = load_copies;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
        else if (valid_reg && out_ready)
        begin
            cnt_next = cnt_reg - COPIES_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= load_sample;
            chan_reg   <= load_channel;
        end
    end

    assign out_valid      = valid_reg;
    assign sample         = sample_reg;
    assign sample_channel = chan_reg;
    assign last           = (cnt_reg == COPIES_W'(1));

`ifndef SYNTHESIS
    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cnt_reg != '0) && (cnt_reg <= COPIES_W'(16)))
        else $error("repeat count out of range");
    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result slot overwritten");
`endif

endmodule
`default_nettype wire
